/* design/sne_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted node entry table.
// No dependencies; imported by every module of the block.
package sne_pkg;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed field widths
  localparam int POS_OUT_W   = 6;
  localparam int TOTAL_OUT_W = 7;
  localparam int SUM_W       = 33;

  // Max-tree leaf group size
  localparam int TREE_GROUP = 8;

  // Register reset values
  localparam logic [15:0] PAGE_BYTES_RST     = 16'd4096;
  localparam logic [7:0]  BASE_OVERHEAD_RST  = 8'd8;
  localparam logic [7:0]  ENTRY_OVERHEAD_RST = 8'd12;
  localparam logic [7:0]  SUBTREE_EXTRA_RST  = 8'd8;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_POP    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_ROOM = 2'd1,
    STATUS_BAD_IDX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_PAGE_BYTES     = 2'd0,
    REG_BASE_OVERHEAD  = 2'd1,
    REG_ENTRY_OVERHEAD = 2'd2,
    REG_SUBTREE_EXTRA  = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] distance;
    logic [31:0] object_handle;
    logic [31:0] page_id;
    logic [31:0] radius;
    logic [15:0] object_bytes;
    logic [5:0]  index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] out_handle;
    logic [31:0] out_page_id;
    logic [31:0] out_distance;
    logic [31:0] out_radius;
    logic [6:0]  entry_total;
    logic [15:0] bytes_in_use;
    logic [32:0] covering_radius;
  } rsp_t;

  // Per-entry payload held in a cell (key travels separately, its width is a parameter)
  typedef struct packed {
    logic [31:0]      handle;
    logic [31:0]      page_id;
    logic [31:0]      radius;
    logic [15:0]      size;
    logic [SUM_W-1:0] sum;     // key + radius, precomputed on insert
  } cell_data_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic insert;
    logic remove;
    logic clear;
  } cell_cmd_t;

endpackage

/* design/sorted_node_entry_table.sv */
`timescale 1ns / 1ps
// Sorted node entry table: keeps up to MAX_ENTRIES entries in ascending distance order
// in a chain of cells, with a page byte budget. Each request word (insert, remove at
// index, pop last, clear) yields exactly one response word. A request is taken only
// when the control is idle; its response is registered after the execute, settle and
// emit states, and the next request can be taken once the control is idle again.
// The chain shifts in the execute state; the covering radius (max of distance +
// radius) then passes the registered group maxima of the max tree. A response
// waiting for rsp_ready does not block the next request, but holds the following
// response back. Config writes (cfg_index 0..3) are always ready out of reset and
// should only be issued while idle.
// Depends on sne_pkg, sne_cell, sne_max_tree.
module sorted_node_entry_table import sne_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W = $clog2(MAX_ENTRIES);

  // ---------------------------------------------------------------- config
  logic [15:0] page_bytes;
  logic [7:0]  base_overhead;
  logic [7:0]  entry_overhead;
  logic [7:0]  subtree_extra;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes     <= PAGE_BYTES_RST;
      base_overhead  <= BASE_OVERHEAD_RST;
      entry_overhead <= ENTRY_OVERHEAD_RST;
      subtree_extra  <= SUBTREE_EXTRA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAGE_BYTES:     page_bytes     <= cfg_data;
        REG_BASE_OVERHEAD:  base_overhead  <= cfg_data[7:0];
        REG_ENTRY_OVERHEAD: entry_overhead <= cfg_data[7:0];
        REG_SUBTREE_EXTRA:  subtree_extra  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  state_t state, state_next;
  req_t   item;                  // request word under work
  logic   req_take;

  assign req_ready = (state == ST_IDLE) && !rst;
  assign req_take  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (req_take) begin
      item <= req;
    end
  end

  // ---------------------------------------------------------------- cell chain
  logic [KEY_BITS-1:0] cell_key   [MAX_ENTRIES];
  cell_data_t          cell_data  [MAX_ENTRIES];
  logic [SUM_W-1:0]    cell_sum   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES-1:0] cell_le;

  cell_cmd_t           cmd;
  logic [KEY_BITS-1:0] new_key;
  cell_data_t          new_data;
  logic [CNT_W-1:0]    sel;      // remove / pop position

  assign new_key          = item.distance[KEY_BITS-1:0];
  assign new_data.handle  = item.object_handle;
  assign new_data.page_id = item.page_id;
  assign new_data.radius  = item.radius;
  assign new_data.size    = item.object_bytes;
  assign new_data.sum     = {1'b0, 32'(new_key)} + {1'b0, item.radius};

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] l_key, r_key;
    cell_data_t          l_data, r_data;
    logic                l_valid, l_le, r_valid;

    // slot 0 sees a virtual left neighbor that sorts before everything
    if (i == 0) begin : g_first
      assign l_key   = new_key;
      assign l_data  = new_data;
      assign l_valid = 1'b0;
      assign l_le    = 1'b1;
    end else begin : g_mid_l
      assign l_key   = cell_key[i-1];
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_le    = cell_le[i-1];
    end

    // last slot empties on a removal
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign r_key   = cell_key[i];
      assign r_data  = cell_data[i];
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_key   = cell_key[i+1];
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    sne_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .probe_key   (new_key),
      .rm_pos      (sel),
      .new_key     (new_key),
      .new_data    (new_data),
      .left_key    (l_key),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .left_le     (l_le),
      .right_key   (r_key),
      .right_data  (r_data),
      .right_valid (r_valid),
      .key         (cell_key[i]),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .le          (cell_le[i]),
      .sum         (cell_sum[i])
    );
  end

  // covering radius: group maxima are registered in the cycle after the chain shifts
  logic [SUM_W-1:0] cover_radius;

  sne_max_tree #(.N(MAX_ENTRIES)) u_tree (
    .clk     (clk),
    .leaf    (cell_sum),
    .max_out (cover_radius)
  );

  // ---------------------------------------------------------------- step logic
  logic [CNT_W-1:0] count, count_next;
  logic [15:0]      used, used_next;

  logic [17:0]         ins_cost;
  logic                ins_ok;
  logic [POS_W-1:0]    ins_pos;
  logic                prev_le;
  logic                rm_bad;
  logic [KEY_BITS-1:0] sel_key;
  cell_data_t          sel_data;
  logic [15:0]         rm_cost;

  // result fields captured at the end of the shift cycle
  logic [1:0]  res_status, res_status_next;
  logic [5:0]  res_pos, res_pos_next;
  logic [31:0] res_handle, res_handle_next;
  logic [31:0] res_page, res_page_next;
  logic [31:0] res_dist, res_dist_next;
  logic [31:0] res_radius, res_radius_next;

  always_comb begin
    ins_cost = 18'(item.object_bytes) + 18'(entry_overhead)
             + ((item.page_id != '0) ? 18'(subtree_extra) : 18'd0);
    ins_ok   = ((18'(used) + ins_cost) <= 18'(page_bytes))
            && (count != CNT_W'(MAX_ENTRIES));

    // insert goes at the first slot that is empty or whose key is above the new one
    ins_pos = '0;
    prev_le = 1'b1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!cell_le[i] && prev_le) begin
        ins_pos = POS_W'(i);
      end
      prev_le = cell_le[i];
    end

    if (item.mode == MODE_POP) begin
      sel    = count - 1'b1;
      rm_bad = (count == '0);
    end else begin
      sel    = CNT_W'(item.index);
      rm_bad = (32'(item.index) >= 32'(count));
    end

    sel_key  = cell_key[0];
    sel_data = cell_data[0];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (CNT_W'(i) == sel) begin
        sel_key  = cell_key[i];
        sel_data = cell_data[i];
      end
    end
    rm_cost = sel_data.size + 16'(entry_overhead)
            + ((sel_data.page_id != '0) ? 16'(subtree_extra) : 16'd0);
  end

  always_comb begin
    cmd             = '0;
    count_next      = count;
    used_next       = used;
    res_status_next = STATUS_OK;
    res_pos_next    = '0;
    res_handle_next = '0;
    res_page_next   = '0;
    res_dist_next   = '0;
    res_radius_next = '0;

    case (item.mode) inside
      MODE_INSERT: begin
        if (ins_ok) begin
          cmd.insert      = (state == ST_EXEC);
          count_next      = count + 1'b1;
          used_next       = used + ins_cost[15:0];
          res_pos_next    = POS_OUT_W'(ins_pos);
          res_handle_next = item.object_handle;
          res_page_next   = item.page_id;
          res_dist_next   = 32'(new_key);
          res_radius_next = item.radius;
        end else begin
          res_status_next = STATUS_NO_ROOM;
        end
      end
      MODE_REMOVE, MODE_POP: begin
        if (rm_bad) begin
          res_status_next = STATUS_BAD_IDX;
        end else begin
          cmd.remove      = (state == ST_EXEC);
          count_next      = count - 1'b1;
          used_next       = used - rm_cost;
          res_pos_next    = POS_OUT_W'(sel);
          res_handle_next = sel_data.handle;
          res_page_next   = sel_data.page_id;
          res_dist_next   = 32'(sel_key);
          res_radius_next = sel_data.radius;
        end
      end
      default: begin  // clear
        cmd.clear  = (state == ST_EXEC);
        count_next = '0;
        used_next  = 16'(base_overhead);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= 16'(BASE_OVERHEAD_RST);
    end else if (state == ST_EXEC) begin
      count <= count_next;
      used  <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res_status <= res_status_next;
      res_pos    <= res_pos_next;
      res_handle <= res_handle_next;
      res_page   <= res_page_next;
      res_dist   <= res_dist_next;
      res_radius <= res_radius_next;
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC:   state_next = ST_SETTLE;
      ST_SETTLE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!rsp_valid || rsp_ready) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.status          <= res_status;
      rsp.position        <= res_pos;
      rsp.out_handle      <= res_handle;
      rsp.out_page_id     <= res_page;
      rsp.out_distance    <= res_dist;
      rsp.out_radius      <= res_radius;
      rsp.entry_total     <= TOTAL_OUT_W'(count);
      rsp.bytes_in_use    <= used;
      rsp.covering_radius <= cover_radius;
    end
  end

  // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
  // occupied slots always match the entry count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(cell_valid))
    else $error("entry count differs from occupied cells");

  // occupied slots form a contiguous run from slot 0
  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("occupied cells not contiguous");

  // a new response only comes out of the emit state
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_EMIT))
    else $error("response raised outside emit");
`endif

endmodule

/* design/sne_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted entry chain: holds an entry and shifts with its neighbors.
// Depends on sne_pkg.
module sne_cell import sne_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int CNT_W    = 7,
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_cmd_t           cmd,
  input  logic [KEY_BITS-1:0] probe_key,
  input  logic [CNT_W-1:0]    rm_pos,
  input  logic [KEY_BITS-1:0] new_key,
  input  cell_data_t          new_data,
  input  logic [KEY_BITS-1:0] left_key,
  input  cell_data_t          left_data,
  input  logic                left_valid,
  input  logic                left_le,
  input  logic [KEY_BITS-1:0] right_key,
  input  cell_data_t          right_data,
  input  logic                right_valid,
  output logic [KEY_BITS-1:0] key,
  output cell_data_t          data,
  output logic                valid,
  output logic                le,
  output logic [SUM_W-1:0]    sum
);

  logic shift_in;   // insert lands at or below this slot
  logic shift_out;  // removal at or below this slot

  assign le        = valid && (key <= probe_key);
  assign sum       = valid ? data.sum : '0;
  assign shift_in  = cmd.insert && !le;
  assign shift_out = cmd.remove && (CNT_W'(CELL_IDX) >= rm_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (shift_in) begin
      valid <= left_le ? 1'b1 : left_valid;
    end else if (shift_out) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_in) begin
      if (left_le) begin
        key  <= new_key;
        data <= new_data;
      end else begin
        key  <= left_key;
        data <= left_data;
      end
    end else if (shift_out) begin
      key  <= right_key;
      data <= right_data;
    end
  end

endmodule

/* design/sne_max_tree.sv */
`timescale 1ns / 1ps
// Two-level max tree over the cell sums; group maxima are registered.
// Depends on sne_pkg.
module sne_max_tree import sne_pkg::*; #(
  parameter int N = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic [SUM_W-1:0] leaf [N],
  output logic [SUM_W-1:0] max_out
);

  localparam int NG = (N + TREE_GROUP - 1) / TREE_GROUP;

  logic [SUM_W-1:0] grp_comb [NG];
  logic [SUM_W-1:0] grp      [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_comb[g] = '0;
      for (int k = 0; k < TREE_GROUP; k++) begin
        if (g * TREE_GROUP + k < N) begin
          if (leaf[g * TREE_GROUP + k] > grp_comb[g]) begin
            grp_comb[g] = leaf[g * TREE_GROUP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_comb;
  end

  always_comb begin
    max_out = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp[g] > max_out) begin
        max_out = grp[g];
      end
    end
  end

endmodule

/* test/entry_table_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the sorted node entry table: mirrors the entry list and the page
// byte budget, predicts every response word and compares it with the block's output.
// Depends on sne_pkg.
module entry_table_checker import sne_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  rsp_t        rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          awaited
);

  localparam int DEPTH = MAX_ENTRIES_DEF;

  // Mirror of the table
  logic [31:0] dist_mem   [DEPTH];
  logic [31:0] handle_mem [DEPTH];
  logic [31:0] page_mem   [DEPTH];
  logic [31:0] radius_mem [DEPTH];
  logic [15:0] size_mem   [DEPTH];
  int          count;
  logic [15:0] used;

  // Mirror of the registers
  logic [15:0] page_limit;
  logic [7:0]  base_oh;
  logic [7:0]  entry_oh;
  logic [7:0]  subtree_oh;

  rsp_t awaited_words [$];

  function automatic logic [31:0] cost_of(input logic [15:0] bytes, input logic [31:0] page);
    logic [31:0] c;
    c = 32'(bytes) + 32'(entry_oh);
    if (page != 32'd0)
      c = c + 32'(subtree_oh);
    return c;
  endfunction

  function automatic void describe(inout rsp_t w, input int at);
    w.position     = at[5:0];
    w.out_handle   = handle_mem[at];
    w.out_page_id  = page_mem[at];
    w.out_distance = dist_mem[at];
    w.out_radius   = radius_mem[at];
  endfunction

  // Take one entry out, close the gap, give its bytes back (wraps at 16 bits)
  function automatic void drop_entry(input int at);
    logic [31:0] c;
    c = cost_of(size_mem[at], page_mem[at]);
    used = used - c[15:0];
    for (int i = at; i + 1 < count; i++) begin
      dist_mem[i]   = dist_mem[i + 1];
      handle_mem[i] = handle_mem[i + 1];
      page_mem[i]   = page_mem[i + 1];
      radius_mem[i] = radius_mem[i + 1];
      size_mem[i]   = size_mem[i + 1];
    end
    count = count - 1;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t        w;
    int          p;
    logic [31:0] c;
    logic [32:0] best;
    logic [32:0] s;
    w = '0;
    w.status = STATUS_OK;
    case (mode_t'(r.mode))
      MODE_INSERT: begin
        c = cost_of(r.object_bytes, r.page_id);
        if (32'(used) + c > 32'(page_limit) || count >= DEPTH) begin
          w.status = STATUS_NO_ROOM;
        end else begin
          // Lands after any equal distances
          p = count;
          while (p > 0 && r.distance < dist_mem[p - 1]) begin
            dist_mem[p]   = dist_mem[p - 1];
            handle_mem[p] = handle_mem[p - 1];
            page_mem[p]   = page_mem[p - 1];
            radius_mem[p] = radius_mem[p - 1];
            size_mem[p]   = size_mem[p - 1];
            p = p - 1;
          end
          dist_mem[p]   = r.distance;
          handle_mem[p] = r.object_handle;
          page_mem[p]   = r.page_id;
          radius_mem[p] = r.radius;
          size_mem[p]   = r.object_bytes;
          count = count + 1;
          used  = used + c[15:0];
          describe(w, p);
        end
      end
      MODE_REMOVE: begin
        if (int'(r.index) >= count) begin
          w.status = STATUS_BAD_IDX;
        end else begin
          describe(w, int'(r.index));
          drop_entry(int'(r.index));
        end
      end
      MODE_POP: begin
        if (count == 0) begin
          w.status = STATUS_BAD_IDX;
        end else begin
          describe(w, count - 1);
          drop_entry(count - 1);
        end
      end
      MODE_CLEAR: begin
        count = 0;
        used  = {8'd0, base_oh};
      end
    endcase
    best = '0;
    for (int i = 0; i < count; i++) begin
      s = {1'b0, dist_mem[i]} + {1'b0, radius_mem[i]};
      if (s > best)
        best = s;
    end
    w.entry_total     = count[6:0];
    w.bytes_in_use    = used;
    w.covering_radius = best;
    return w;
  endfunction

  function automatic bit field_differs(input string name, input logic [32:0] want,
                                       input logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit word_differs(input rsp_t want, input rsp_t got);
    bit bad;
    bad = 1'b0;
    bad |= field_differs("status", want.status, got.status);
    bad |= field_differs("position", want.position, got.position);
    bad |= field_differs("out_handle", want.out_handle, got.out_handle);
    bad |= field_differs("out_page_id", want.out_page_id, got.out_page_id);
    bad |= field_differs("out_distance", want.out_distance, got.out_distance);
    bad |= field_differs("out_radius", want.out_radius, got.out_radius);
    bad |= field_differs("entry_total", want.entry_total, got.entry_total);
    bad |= field_differs("bytes_in_use", want.bytes_in_use, got.bytes_in_use);
    bad |= field_differs("covering_radius", want.covering_radius, got.covering_radius);
    return bad;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      count      = 0;
      used       = {8'd0, BASE_OVERHEAD_RST};
      page_limit = PAGE_BYTES_RST;
      base_oh    = BASE_OVERHEAD_RST;
      entry_oh   = ENTRY_OVERHEAD_RST;
      subtree_oh = SUBTREE_EXTRA_RST;
      awaited_words.delete();
      awaited <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_PAGE_BYTES:     page_limit = cfg_data;
          REG_BASE_OVERHEAD:  base_oh    = cfg_data[7:0];
          REG_ENTRY_OVERHEAD: entry_oh   = cfg_data[7:0];
          REG_SUBTREE_EXTRA:  subtree_oh = cfg_data[7:0];
        endcase
      end
      // Compare before queueing, so a word never meets its own prediction
      if (rsp_valid && rsp_ready) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: response word with nothing expected, got %h", $time, rsp);
          fail_count <= fail_count + 1;
        end else if (word_differs(awaited_words.pop_front(), rsp)) begin
          fail_count <= fail_count + 1;
        end
      end
      if (req_valid && req_ready)
        awaited_words.push_back(apply_request(req));
      awaited <= awaited_words.size();
    end
  end

endmodule

/* test/sorted_node_entry_table_test.sv */
`timescale 1ns / 1ps
// Testbench top for the sorted node entry table: directed and random request words
// under several register settings and idling patterns; verdict from the checker.
// Depends on sne_pkg, sorted_node_entry_table and entry_table_checker.
module sorted_node_entry_table_test;
  import sne_pkg::*;

  // Watchdog limit; leaves a wide margin over the slowest phases
  localparam int CYCLE_LIMIT = 400000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  req_t        req       = '0;
  logic        rsp_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_PAGE_BYTES;
  logic [15:0] cfg_data  = '0;
  logic        req_ready;
  logic        rsp_valid;
  logic        cfg_ready;
  rsp_t        rsp;

  int fails;
  int awaited;
  int cycles       = 0;
  int req_idle_pct = 0;   // only touched by the stimulus process
  int rsp_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_node_entry_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  entry_table_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fails),
    .awaited    (awaited)
  );

  // Receiver: stalls at random per cycle at the current rate
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic req_t make_req(input mode_t m, input logic [31:0] distance,
                                    input logic [31:0] handle, input logic [31:0] page,
                                    input logic [31:0] rad, input logic [15:0] bytes,
                                    input logic [5:0] ix);
    req_t r;
    r.mode          = m;
    r.distance      = distance;
    r.object_handle = handle;
    r.page_id       = page;
    r.radius        = rad;
    r.object_bytes  = bytes;
    r.index         = ix;
    return r;
  endfunction

  // Random word: mostly small sizes so the budget admits entries, small distances
  // often so ties occur, and now and then the field extremes.
  function automatic req_t random_request(input int insert_pct, input int clear_pct);
    req_t r;
    int   pick;
    int   roll;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct)
      r.mode = MODE_INSERT;
    else if (pick >= 100 - clear_pct)
      r.mode = MODE_CLEAR;
    else if (pick[0])
      r.mode = MODE_REMOVE;
    else
      r.mode = MODE_POP;

    roll = $urandom_range(0, 99);
    r.distance = (roll < 30) ? 32'($urandom_range(0, 15)) :
                 (roll < 35) ? 32'hFFFF_FFFF : 32'($urandom);
    roll = $urandom_range(0, 99);
    r.radius = (roll < 30) ? 32'($urandom_range(0, 255)) :
               (roll < 35) ? 32'hFFFF_FFFF : 32'($urandom);
    roll = $urandom_range(0, 99);
    r.page_id = (roll < 40) ? 32'd0 : (roll < 45) ? 32'hFFFF_FFFF : 32'($urandom);
    r.object_handle = $urandom;
    roll = $urandom_range(0, 99);
    r.object_bytes = (roll < 15) ? 16'd0 :
                     (roll < 75) ? 16'($urandom_range(1, 200)) :
                     (roll < 80) ? 16'hFFFF : 16'($urandom_range(0, 65535));
    r.index = ($urandom_range(0, 99) < 60) ? 6'($urandom_range(0, 15)) :
                                             6'($urandom_range(0, 63));
    return r;
  endfunction

  // Offer one word and hold it until taken. Valid drops only when a gap is
  // inserted, so back-to-back words keep it high without a second assignment.
  task automatic send_word(input req_t r);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < req_idle_pct)
      gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last register
  task automatic put_register(input reg_index_t ri, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted word has come back. The first
  // edge lets the checker count the word accepted last.
  task automatic drain;
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited != 0);
  endtask

  task automatic run_phase(input logic [15:0] page, input logic [7:0] base,
                           input logic [7:0] ent, input logic [7:0] sub,
                           input int words, input int insert_pct, input int clear_pct);
    put_register(REG_PAGE_BYTES, page);
    put_register(REG_BASE_OVERHEAD, {8'd0, base});
    put_register(REG_ENTRY_OVERHEAD, {8'd0, ent});
    put_register(REG_SUBTREE_EXTRA, {8'd0, sub});
    cfg_valid <= 1'b0;
    repeat (words) send_word(random_request(insert_pct, clear_pct));
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Sender idles often-ish, receiver stalls hard
    req_idle_pct = 31;
    rsp_idle_pct <= 87;

    // Directed words at the reset register values (page 4096, overheads 8/12/8)
    send_word(make_req(MODE_POP, 32'd1, 32'd1, 32'd1, 32'd1, 16'd1, 6'd0));    // pop, empty
    send_word(make_req(MODE_REMOVE, 32'd1, 32'd1, 32'd1, 32'd1, 16'd1, 6'd0)); // remove, empty
    send_word(make_req(MODE_INSERT, 32'h100, 32'd1, 32'd0, 32'd0, 16'd0, 6'd0));
    // all-ones entry: covering radius carries into bit 32
    send_word(make_req(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'd10, 6'd63));
    // equal distance goes behind the first one
    send_word(make_req(MODE_INSERT, 32'h100, 32'd2, 32'd5, 32'h80, 16'd20, 6'd0));
    send_word(make_req(MODE_INSERT, 32'd0, 32'd3, 32'd0, 32'd0, 16'd0, 6'd0));  // new head
    send_word(make_req(MODE_INSERT, 32'd9, 32'd4, 32'd0, 32'd0, 16'hFFFF, 6'd0)); // no room
    send_word(make_req(MODE_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd63)); // bad index
    send_word(make_req(MODE_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd4));  // index == count
    send_word(make_req(MODE_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd1));  // middle
    send_word(make_req(MODE_REMOVE, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0));  // head
    send_word(make_req(MODE_POP, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0));
    send_word(make_req(MODE_POP, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0));
    send_word(make_req(MODE_POP, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0));    // empty again
    send_word(make_req(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                       16'($urandom), 6'($urandom)));
    // 8 + 4076 + 12 fills the page to the byte
    send_word(make_req(MODE_INSERT, 32'd7, 32'd5, 32'd0, 32'd0, 16'd4076, 6'd0));
    send_word(make_req(MODE_INSERT, 32'd8, 32'd6, 32'd0, 32'd0, 16'd0, 6'd0));  // no room
    send_word(make_req(MODE_POP, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0));
    // one byte over budget
    send_word(make_req(MODE_INSERT, 32'd7, 32'd7, 32'd0, 32'd0, 16'd4077, 6'd0));
    // exact fit counting the subtree extra
    send_word(make_req(MODE_INSERT, 32'd7, 32'd8, 32'd1, 32'd3, 16'd4068, 6'd0));
    send_word(make_req(MODE_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 6'd0));
    drain();

    // Largest overheads: the budget runs out or the table fills
    run_phase(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 280, 60, 2);
    // All zero: only zero-cost inserts fit, and only after a clear
    run_phase(16'd0, 8'd0, 8'd0, 8'd0, 200, 60, 5);

    // Swap the idling rates
    req_idle_pct = 87;
    rsp_idle_pct <= 31;

    // Entries left from the zero-cost phase now cost more on removal: used wraps
    run_phase(16'd2000, 8'd8, 8'd12, 8'd8, 300, 58, 2);
    // Roomy page with no overhead: mostly full-table rejections
    run_phase(16'hFFFF, 8'd0, 8'd0, 8'd0, 300, 70, 1);

    // No idling on either side
    req_idle_pct = 0;
    rsp_idle_pct <= 0;

    run_phase(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 300, 58, 2);
    run_phase(PAGE_BYTES_RST, BASE_OVERHEAD_RST, ENTRY_OVERHEAD_RST, SUBTREE_EXTRA_RST,
              300, 58, 2);

    // Let any stray word show up before the verdict
    repeat (8) @(posedge clk);
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
design/sne_pkg.sv
design/sne_cell.sv
design/sne_max_tree.sv
design/sorted_node_entry_table.sv
test/entry_table_checker.sv
test/sorted_node_entry_table_test.sv
